/* hw/rtl/sorted_priority_queue_defines.svh */
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int FUNC_W = 2;
  localparam int CAP_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUERY = 2'd0,
    FUNC_PUSH  = 2'd1,
    FUNC_POP   = 2'd2
  } func_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                            clk,
  input  cell_ctl_t                       ctl,
  input  logic                            occ,
  input  logic                            at_tail,
  input  logic [PAYLOAD_BITS-1:0]         new_payload,
  input  logic signed [PRIORITY_BITS-1:0] new_priority,
  input  logic                            left_ge,
  input  logic [PAYLOAD_BITS-1:0]         left_payload,
  input  logic signed [PRIORITY_BITS-1:0] left_priority,
  input  logic [PAYLOAD_BITS-1:0]         right_payload,
  input  logic signed [PRIORITY_BITS-1:0] right_priority,
  output logic                            ge,
  output logic [PAYLOAD_BITS-1:0]         slot_payload,
  output logic signed [PRIORITY_BITS-1:0] slot_priority,
  output logic [PAYLOAD_BITS-1:0]         payload_next,
  output logic signed [PRIORITY_BITS-1:0] priority_next
);

  // The new entry goes ahead of this slot when its priority is equal or higher.
  assign ge = occ && (new_priority >= slot_priority);

  always_comb begin
    payload_next  = slot_payload;
    priority_next = slot_priority;
    if (ctl.push) begin
      if (left_ge) begin
        payload_next  = left_payload;
        priority_next = left_priority;
      end else if (ge || at_tail) begin
        payload_next  = new_payload;
        priority_next = new_priority;
      end
    end else if (ctl.pop) begin
      payload_next  = right_payload;
      priority_next = right_priority;
    end
  end

  always_ff @(posedge clk) begin
    slot_payload  <= payload_next;
    slot_priority <= priority_next;
  end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue built as a chain of slot cells.
`timescale 1ns / 1ps
// Bounded priority queue kept sorted by descending signed priority, head in
// slot 0. A push inserts ahead of all entries of equal or lower priority, so
// the newest of equal priorities is served first; a push on a full queue and
// a pop on an empty queue are ignored and flagged as rejected. Each input
// transfer yields exactly one result transfer that shows the queue after the
// operation: head entry (zero when empty), count, empty and full flags. The
// queue is a row of DEPTH cells; on a push every cell compares the new
// priority with its own entry and either keeps it, takes the new entry, or
// takes its left neighbor's entry, and on a pop every cell takes its right
// neighbor's entry, so all cells update together, in parallel. The result
// sits in an output register the cycle after the input transfer, and a new
// item is taken while that result is being taken, so the block sustains one
// item per cycle whenever out_ready is high. The critical path is one
// PRIORITY_BITS-wide compare per cell plus the neighbor select. The capacity
// register takes effect on the next item; zero reads as one, values above
// DEPTH saturate to DEPTH. No clearing pass follows reset.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CAP_W-1:0]                    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [FUNC_W-1:0]                   func,
  input  logic [PAYLOAD_BITS-1:0]             payload,
  input  logic signed [PRIORITY_BITS-1:0]     priority_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [PAYLOAD_BITS-1:0]             head_payload,
  output logic signed [PRIORITY_BITS-1:0]     head_priority,
  output logic [$clog2(DEPTH+1)-1:0]          count,
  output logic                                is_empty,
  output logic                                is_full,
  output logic                                rejected
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Effective capacity, already clamped into 1..DEPTH when written.
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic             accept;
  logic             full_now;
  logic             push_ok;
  logic             pop_ok;
  logic             reject_now;
  cell_ctl_t        ctl;

  logic                            ge_row   [DEPTH];
  logic [PAYLOAD_BITS-1:0]         pay_row  [DEPTH];
  logic signed [PRIORITY_BITS-1:0] pri_row  [DEPTH];
  logic [PAYLOAD_BITS-1:0]         pay_next [DEPTH];
  logic signed [PRIORITY_BITS-1:0] pri_next [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full_now = held >= cap;

  // Decode the operation; the unused code behaves as a query.
  always_comb begin
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    reject_now = 1'b0;
    unique case (func_t'(func))
      FUNC_PUSH: begin
        push_ok    = accept && !full_now;
        reject_now = full_now;
      end
      FUNC_POP: begin
        pop_ok     = accept && (held != '0);
        reject_now = (held == '0);
      end
      default: begin
        push_ok = 1'b0;
      end
    endcase
  end

  assign ctl.push = push_ok;
  assign ctl.pop  = pop_ok;

  always_comb begin
    held_next = held;
    if (push_ok) begin
      held_next = held + CNT_W'(1);
    end else if (pop_ok) begin
      held_next = held - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                            lge;
    logic [PAYLOAD_BITS-1:0]         lpay;
    logic signed [PRIORITY_BITS-1:0] lpri;
    logic [PAYLOAD_BITS-1:0]         rpay;
    logic signed [PRIORITY_BITS-1:0] rpri;

    if (i == 0) begin : g_first
      assign lge  = 1'b0;
      assign lpay = '0;
      assign lpri = '0;
    end else begin : g_inner
      assign lge  = ge_row[i-1];
      assign lpay = pay_row[i-1];
      assign lpri = pri_row[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rpay = '0;
      assign rpri = '0;
    end else begin : g_body
      assign rpay = pay_row[i+1];
      assign rpri = pri_row[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occ           (held > CNT_W'(i)),
      .at_tail       (held == CNT_W'(i)),
      .new_payload   (payload),
      .new_priority  (priority_req),
      .left_ge       (lge),
      .left_payload  (lpay),
      .left_priority (lpri),
      .right_payload (rpay),
      .right_priority(rpri),
      .ge            (ge_row[i]),
      .slot_payload  (pay_row[i]),
      .slot_priority (pri_row[i]),
      .payload_next  (pay_next[i]),
      .priority_next (pri_next[i])
    );
  end

  // Capacity register, clamped on write so the compare stays narrow.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CNT_W'(DEPTH);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap <= CNT_W'(1);
      end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
        cap <= CNT_W'(DEPTH);
      end else begin
        cap <= CNT_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result reflects the queue after the operation, taken from the
  // next-state values of the head cell.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_payload  <= (held_next == '0) ? '0 : pay_next[0];
      head_priority <= (held_next == '0) ? '0 : pri_next[0];
      count         <= held_next;
      is_empty      <= (held_next == '0);
      is_full       <= (held_next >= cap);
      rejected      <= reject_now;
    end
  end

endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"
module spq_checker #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [PAYLOAD_BITS-1:0]         head_payload,
  input logic signed [PRIORITY_BITS-1:0] head_priority,
  input logic [$clog2(DEPTH+1)-1:0]      count,
  input logic                            is_empty,
  input logic                            is_full,
  input logic                            rejected
);

  // A stalled result must hold its count, head payload and rejected flag until it is taken.
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(count) && $stable(head_payload) && $stable(rejected), "stalled result changed")

  // With no result waiting the block must take a new item.
  `SPQ_ASSERT_SAME(a_ready_free, clk, rst, !out_valid, in_ready, "input blocked with no pending result")

  // The empty flag must agree with the reported count.
  `SPQ_ASSERT_SAME(a_empty_count, clk, rst, out_valid, is_empty == (count == '0), "empty flag disagrees with count")

  // An empty queue reports a zero head.
  `SPQ_ASSERT_SAME(a_empty_head, clk, rst, out_valid && is_empty, head_payload == '0 && head_priority == '0, "nonzero head on empty queue")

  // Capacity is at least one, so empty and full never show together.
  `SPQ_ASSERT_SAME(a_empty_full, clk, rst, out_valid, !(is_empty && is_full), "empty and full both set")

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH        (DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_spq_checker (.*);
